FILE: hdl/qsvg_pkg.sv
// qsvg_pkg: shared types and constants for the qubit state-vector gate engine.
// No dependencies; used by every module of the block but qsvg_ram, and by its checker.
package qsvg_pkg;

  // Instruction codes carried on in_action
  typedef enum logic [2:0] {
    ACT_INIT = 3'd0,
    ACT_HAD  = 3'd1,
    ACT_NOT  = 3'd2,
    ACT_CNOT = 3'd3,
    ACT_READ = 3'd4
  } action_t;

  // Control word for one amplitude pair entering the butterfly pipe
  typedef struct packed {
    logic vld;   // pair is written back
    logic had;   // 1: hadamard butterfly, 0: swap
    logic par;   // parity of the lower index: 1 means it sits in bank 1
  } pair_cmd_t;

  localparam int FRAC_BITS = 16;
  // round(2^16 / sqrt(2)) and unit gain, both as 18-bit signed coefficients
  localparam logic signed [17:0] COEF_INV_SQRT2 = 18'sd46341;
  localparam logic signed [17:0] COEF_UNIT      = 18'sd65536;

endpackage

FILE: hdl/qubit_state_vector_gates.sv
// Qubit state-vector gate engine. A gate on one qubit is one pass over the 2^(n-1) amplitude
// pairs and a drain of the butterfly pipe; an all-qubit gate takes n such passes; init clears
// all 2^(MAX_QUBITS-1) rows of each bank; a read result is held in the result register.
// Throughput is one request at a time, set by the single butterfly pipe doing one pair a cycle.
// Reset (rst_n low, synchronous) sets num_qubits to 1 and runs a clearing pass with
// in_ready low; a num_qubits write also reinitializes the vector the same way.
module qubit_state_vector_gates #(
  parameter int MAX_QUBITS = 6,
  parameter int AMP_WIDTH  = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_action,
  input  logic                        in_all_qubits,
  input  logic [2:0]                  in_target_qubit,
  input  logic [2:0]                  in_control_qubit,
  input  logic [5:0]                  in_read_index,
  // num_qubits register
  input  logic                        cfg_wr_en,
  input  logic [2:0]                  cfg_wr_data,
  // amplitude result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [AMP_WIDTH-1:0] out_amp_real,
  output logic signed [AMP_WIDTH-1:0] out_amp_imag,
  output logic [5:0]                  out_amp_index
);

  // The vector is split in two banks by index parity: the two members of any pair
  // differ in one bit and so always live in different banks, which lets one pair
  // be read and written back every cycle. Each bank word is {imag, real}.
  localparam int ADDR_W     = (MAX_QUBITS > 1) ? MAX_QUBITS - 1 : 1;
  localparam int BANK_DEPTH = 1 << (MAX_QUBITS - 1);
  localparam int WORD_W     = 2 * AMP_WIDTH;
  // |0..0> amplitude: 1.0 in Q.16, saturated if the word is too narrow
  localparam int ONE_INT    = (AMP_WIDTH >= 18) ? (1 << 16) : ((1 << (AMP_WIDTH - 1)) - 1);
  localparam logic [AMP_WIDTH-1:0] AMP_ONE = AMP_WIDTH'(ONE_INT);

  qsvg_pkg::pair_cmd_t  cmd;
  logic                 busy;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr0, rd_addr1;
  logic [WORD_W-1:0]    rd0, rd1;
  logic                 clr_we;
  logic [ADDR_W-1:0]    clr_addr;
  logic                 bf_we;
  logic [ADDR_W-1:0]    bf_addr0, bf_addr1;
  logic [WORD_W-1:0]    bf_data0, bf_data1;
  logic                 we;
  logic [ADDR_W-1:0]    waddr0, waddr1;
  logic [WORD_W-1:0]    wdata0, wdata1;
  logic [AMP_WIDTH-1:0] amp_re, amp_im;

  qsvg_seq #(
    .MAX_QUBITS (MAX_QUBITS),
    .AMP_WIDTH  (AMP_WIDTH),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_all_qubits    (in_all_qubits),
    .in_target_qubit  (in_target_qubit),
    .in_control_qubit (in_control_qubit),
    .in_read_index    (in_read_index),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_amp_real     (amp_re),
    .out_amp_imag     (amp_im),
    .out_amp_index    (out_amp_index),
    .rd_en            (rd_en),
    .rd_addr0         (rd_addr0),
    .rd_addr1         (rd_addr1),
    .rd0              (rd0),
    .rd1              (rd1),
    .cmd              (cmd),
    .busy             (busy),
    .clr_we           (clr_we),
    .clr_addr         (clr_addr)
  );

  qsvg_bfly #(
    .AMP_WIDTH (AMP_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_bfly (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .addr0    (rd_addr0),
    .addr1    (rd_addr1),
    .rd0      (rd0),
    .rd1      (rd1),
    .busy     (busy),
    .wr_en    (bf_we),
    .wr_addr0 (bf_addr0),
    .wr_addr1 (bf_addr1),
    .wr_data0 (bf_data0),
    .wr_data1 (bf_data1)
  );

  // Clearing writes win over butterfly writes. An init request starts clearing only from
  // idle, when the pipe is empty; a num_qubits write starts it in every state, also mid-gate.
  always_comb begin
    we     = clr_we | bf_we;
    waddr0 = clr_we ? clr_addr : bf_addr0;
    waddr1 = clr_we ? clr_addr : bf_addr1;
    if (clr_we) begin
      // index 0 has even parity and sits at bank 0, row 0
      wdata0 = (clr_addr == '0) ? {{AMP_WIDTH{1'b0}}, AMP_ONE} : '0;
      wdata1 = '0;
    end else begin
      wdata0 = bf_data0;
      wdata1 = bf_data1;
    end
  end

  qsvg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank0 (
    .clk   (clk),
    .we    (we),
    .waddr (waddr0),
    .wdata (wdata0),
    .re    (rd_en),
    .raddr (rd_addr0),
    .rdata (rd0)
  );

  qsvg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank1 (
    .clk   (clk),
    .we    (we),
    .waddr (waddr1),
    .wdata (wdata1),
    .re    (rd_en),
    .raddr (rd_addr1),
    .rdata (rd1)
  );

  assign out_amp_real = amp_re;
  assign out_amp_imag = amp_im;

endmodule

FILE: hdl/qsvg_ram.sv
// qsvg_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module qsvg_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/qsvg_bfly.sv
// qsvg_bfly: three-stage butterfly pipe, one amplitude pair per cycle.
// Hadamard: (a+b)/sqrt2, (a-b)/sqrt2 rounded and saturated; swap for not/cnot.
// Depends on qsvg_pkg.
module qsvg_bfly #(
  parameter int AMP_WIDTH = 18,
  parameter int ADDR_W    = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  qsvg_pkg::pair_cmd_t      cmd,
  input  logic [ADDR_W-1:0]        addr0,
  input  logic [ADDR_W-1:0]        addr1,
  input  logic [2*AMP_WIDTH-1:0]   rd0,
  input  logic [2*AMP_WIDTH-1:0]   rd1,
  output logic                     busy,
  output logic                     wr_en,
  output logic [ADDR_W-1:0]        wr_addr0,
  output logic [ADDR_W-1:0]        wr_addr1,
  output logic [2*AMP_WIDTH-1:0]   wr_data0,
  output logic [2*AMP_WIDTH-1:0]   wr_data1
);

  localparam int XW = AMP_WIDTH + 1;
  localparam int PW = XW + 18;
  localparam logic signed [PW-1:0] RND  = PW'(1) <<< (qsvg_pkg::FRAC_BITS - 1);
  localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (AMP_WIDTH - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

  function automatic logic [AMP_WIDTH-1:0] round_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    logic signed [PW-1:0] r;
    t = p + RND;
    r = t >>> qsvg_pkg::FRAC_BITS;
    if (r > SMAX) begin
      round_sat = SMAX[AMP_WIDTH-1:0];
    end else if (r < SMIN) begin
      round_sat = SMIN[AMP_WIDTH-1:0];
    end else begin
      round_sat = r[AMP_WIDTH-1:0];
    end
  endfunction

  // stage 1: read data arrives
  qsvg_pkg::pair_cmd_t s1_cmd_r;
  logic [ADDR_W-1:0]   s1_a0_r, s1_a1_r;
  // stage 2: sum/difference or swapped operands
  qsvg_pkg::pair_cmd_t s2_cmd_r;
  logic [ADDR_W-1:0]   s2_a0_r, s2_a1_r;
  logic signed [XW-1:0] s2_x0re_r, s2_x1re_r, s2_x0im_r, s2_x1im_r;
  // stage 3: products
  qsvg_pkg::pair_cmd_t s3_cmd_r;
  logic [ADDR_W-1:0]   s3_a0_r, s3_a1_r;
  logic signed [PW-1:0] s3_p0re_r, s3_p1re_r, s3_p0im_r, s3_p1im_r;

  logic [2*AMP_WIDTH-1:0] word_i, word_j;
  logic signed [AMP_WIDTH-1:0] are, bre, aim, bim;
  logic signed [XW-1:0] x0re_nxt, x1re_nxt, x0im_nxt, x1im_nxt;
  logic signed [17:0] coef;
  logic [AMP_WIDTH-1:0] nire, njre, niim, njim;

  always_comb begin
    word_i = s1_cmd_r.par ? rd1 : rd0;
    word_j = s1_cmd_r.par ? rd0 : rd1;
    are = word_i[AMP_WIDTH-1:0];
    aim = word_i[2*AMP_WIDTH-1:AMP_WIDTH];
    bre = word_j[AMP_WIDTH-1:0];
    bim = word_j[2*AMP_WIDTH-1:AMP_WIDTH];
    if (s1_cmd_r.had) begin
      x0re_nxt = XW'(are) + XW'(bre);
      x1re_nxt = XW'(are) - XW'(bre);
      x0im_nxt = XW'(aim) + XW'(bim);
      x1im_nxt = XW'(aim) - XW'(bim);
    end else begin
      x0re_nxt = XW'(bre);
      x1re_nxt = XW'(are);
      x0im_nxt = XW'(bim);
      x1im_nxt = XW'(aim);
    end
  end

  // swap passes through the multiplier at unit gain
  assign coef = s2_cmd_r.had ? qsvg_pkg::COEF_INV_SQRT2 : qsvg_pkg::COEF_UNIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_cmd_r <= '0;
      s2_cmd_r <= '0;
      s3_cmd_r <= '0;
    end else begin
      s1_cmd_r <= cmd;
      s2_cmd_r <= s1_cmd_r;
      s3_cmd_r <= s2_cmd_r;
    end
    s1_a0_r   <= addr0;
    s1_a1_r   <= addr1;
    s2_a0_r   <= s1_a0_r;
    s2_a1_r   <= s1_a1_r;
    s2_x0re_r <= x0re_nxt;
    s2_x1re_r <= x1re_nxt;
    s2_x0im_r <= x0im_nxt;
    s2_x1im_r <= x1im_nxt;
    s3_a0_r   <= s2_a0_r;
    s3_a1_r   <= s2_a1_r;
    s3_p0re_r <= PW'(s2_x0re_r) * PW'(coef);
    s3_p1re_r <= PW'(s2_x1re_r) * PW'(coef);
    s3_p0im_r <= PW'(s2_x0im_r) * PW'(coef);
    s3_p1im_r <= PW'(s2_x1im_r) * PW'(coef);
  end

  assign nire = round_sat(s3_p0re_r);
  assign njre = round_sat(s3_p1re_r);
  assign niim = round_sat(s3_p0im_r);
  assign njim = round_sat(s3_p1im_r);

  assign busy     = s1_cmd_r.vld | s2_cmd_r.vld | s3_cmd_r.vld;
  assign wr_en    = s3_cmd_r.vld;
  assign wr_addr0 = s3_a0_r;
  assign wr_addr1 = s3_a1_r;
  assign wr_data0 = s3_cmd_r.par ? {njim, njre} : {niim, nire};
  assign wr_data1 = s3_cmd_r.par ? {niim, nire} : {njim, njre};

endmodule

FILE: hdl/qsvg_seq.sv
// qsvg_seq: instruction sequencer: request handshake, qubit-count register,
// clearing pass, pair address generation, amplitude read and result register.
// Depends on qsvg_pkg.
module qsvg_seq #(
  parameter int MAX_QUBITS = 6,
  parameter int AMP_WIDTH  = 18,
  parameter int ADDR_W     = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_action,
  input  logic                    in_all_qubits,
  input  logic [2:0]              in_target_qubit,
  input  logic [2:0]              in_control_qubit,
  input  logic [5:0]              in_read_index,
  input  logic                    cfg_wr_en,
  input  logic [2:0]              cfg_wr_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [AMP_WIDTH-1:0]    out_amp_real,
  output logic [AMP_WIDTH-1:0]    out_amp_imag,
  output logic [5:0]              out_amp_index,
  output logic                    rd_en,
  output logic [ADDR_W-1:0]       rd_addr0,
  output logic [ADDR_W-1:0]       rd_addr1,
  input  logic [2*AMP_WIDTH-1:0]  rd0,
  input  logic [2*AMP_WIDTH-1:0]  rd1,
  output qsvg_pkg::pair_cmd_t     cmd,
  input  logic                    busy,
  output logic                    clr_we,
  output logic [ADDR_W-1:0]       clr_addr
);

  localparam int IDX_W      = MAX_QUBITS;
  localparam int VEC_DEPTH  = 1 << MAX_QUBITS;
  localparam int BANK_DEPTH = (VEC_DEPTH > 2) ? VEC_DEPTH / 2 : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PASS, S_DRAIN, S_READ
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        nq_r, nq_nxt;
  logic [ADDR_W-1:0] pair_r, pair_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [2:0]        qubit_r, qubit_nxt;
  logic [2:0]        ctrl_r, ctrl_nxt;
  logic              had_r, had_nxt;
  logic              cnot_r, cnot_nxt;
  logic              all_r, all_nxt;
  logic [5:0]        ridx_r, ridx_nxt;
  logic              rpar_r, rpar_nxt;
  logic              rzero_r, rzero_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [AMP_WIDTH-1:0] out_re_r, out_re_nxt, out_im_r, out_im_nxt;
  logic [5:0]        out_idx_r, out_idx_nxt;

  logic              accept;
  logic [IDX_W-1:0]  k_ext, low_mask, idx_i, idx_j, ctrl_sh, rd_idx;
  logic              par_i, ctrl_set;
  logic [ADDR_W-1:0] addr_i, addr_j, npairs_m1, raddr;
  logic [2:0]        nq_m1, cfg_clamped;
  logic [2*AMP_WIDTH-1:0] rword;

  // pair k -> lower index i (bit q cleared), upper index j = i | 1<<q
  always_comb begin
    k_ext     = IDX_W'(pair_r);
    low_mask  = ~({IDX_W{1'b1}} << qubit_r);
    idx_i     = ((k_ext & ~low_mask) << 1) | (k_ext & low_mask);
    idx_j     = idx_i | (IDX_W'(1) << qubit_r);
    par_i     = ^idx_i;
    addr_i    = ADDR_W'(idx_i >> 1);
    addr_j    = ADDR_W'(idx_j >> 1);
    ctrl_sh   = idx_i >> ctrl_r;
    ctrl_set  = ctrl_sh[0];
    nq_m1     = nq_r - 3'd1;
    npairs_m1 = ~({ADDR_W{1'b1}} << nq_m1);
    rd_idx    = IDX_W'(in_read_index);
    raddr     = ADDR_W'(rd_idx >> 1);
  end

  // bank of an index is its parity, so i and j never share a bank
  always_comb begin
    cmd.vld  = (state_r == S_PASS) && (!cnot_r || ctrl_set);
    cmd.had  = had_r;
    cmd.par  = par_i;
    rd_en    = (state_r == S_PASS) ||
               (accept && (qsvg_pkg::action_t'(in_action) == qsvg_pkg::ACT_READ));
    rd_addr0 = (state_r == S_PASS) ? (par_i ? addr_j : addr_i) : raddr;
    rd_addr1 = (state_r == S_PASS) ? (par_i ? addr_i : addr_j) : raddr;
    clr_we   = (state_r == S_CLEAR);
    clr_addr = clr_cnt_r;
  end

  always_comb begin
    if (cfg_wr_data == 3'd0) begin
      cfg_clamped = 3'd1;
    end else if (32'(cfg_wr_data) > MAX_QUBITS) begin
      cfg_clamped = 3'(MAX_QUBITS);
    end else begin
      cfg_clamped = cfg_wr_data;
    end
  end

  assign accept = in_valid && (state_r == S_IDLE);
  assign rword  = rpar_r ? rd1 : rd0;

  always_comb begin
    state_nxt     = state_r;
    nq_nxt        = nq_r;
    pair_nxt      = pair_r;
    clr_cnt_nxt   = clr_cnt_r;
    qubit_nxt     = qubit_r;
    ctrl_nxt      = ctrl_r;
    had_nxt       = had_r;
    cnot_nxt      = cnot_r;
    all_nxt       = all_r;
    ridx_nxt      = ridx_r;
    rpar_nxt      = rpar_r;
    rzero_nxt     = rzero_r;
    out_re_nxt    = out_re_r;
    out_im_nxt    = out_im_r;
    out_idx_nxt   = out_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(BANK_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          pair_nxt  = '0;
          ctrl_nxt  = in_control_qubit;
          all_nxt   = in_all_qubits;
          qubit_nxt = in_all_qubits ? 3'd0 : in_target_qubit;
          case (qsvg_pkg::action_t'(in_action))
            qsvg_pkg::ACT_INIT: begin
              state_nxt   = S_CLEAR;
              clr_cnt_nxt = '0;
            end
            qsvg_pkg::ACT_HAD, qsvg_pkg::ACT_NOT: begin
              had_nxt  = (qsvg_pkg::action_t'(in_action) == qsvg_pkg::ACT_HAD);
              cnot_nxt = 1'b0;
              if (in_all_qubits || (in_target_qubit < nq_r)) begin
                state_nxt = S_PASS;
              end
            end
            qsvg_pkg::ACT_CNOT: begin
              had_nxt  = 1'b0;
              cnot_nxt = 1'b1;
              all_nxt  = 1'b0;
              qubit_nxt = in_target_qubit;
              if ((in_target_qubit < nq_r) && (in_control_qubit < nq_r) &&
                  (in_target_qubit != in_control_qubit)) begin
                state_nxt = S_PASS;
              end
            end
            qsvg_pkg::ACT_READ: begin
              ridx_nxt  = in_read_index;
              rpar_nxt  = ^rd_idx;
              rzero_nxt = (32'(in_read_index) >= VEC_DEPTH);
              state_nxt = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_PASS: begin
        if (pair_r == npairs_m1) begin
          pair_nxt  = '0;
          state_nxt = S_DRAIN;
        end else begin
          pair_nxt = pair_r + ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        // next qubit only once every write of this pass has landed
        if (!busy) begin
          if (all_r && (qubit_r < nq_m1)) begin
            qubit_nxt = qubit_r + 3'd1;
            state_nxt = S_PASS;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_READ: begin
        // result slot holds its own copy of the index: ridx_r moves on the next read
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_re_nxt    = rzero_r ? '0 : rword[AMP_WIDTH-1:0];
          out_im_nxt    = rzero_r ? '0 : rword[2*AMP_WIDTH-1:AMP_WIDTH];
          out_idx_nxt   = ridx_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      nq_nxt      = cfg_clamped;
      state_nxt   = S_CLEAR;
      clr_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      nq_r        <= 3'd1;
      pair_r      <= '0;
      clr_cnt_r   <= '0;
      qubit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nq_r        <= nq_nxt;
      pair_r      <= pair_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      qubit_r     <= qubit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ctrl_r    <= ctrl_nxt;
    had_r     <= had_nxt;
    cnot_r    <= cnot_nxt;
    all_r     <= all_nxt;
    ridx_r    <= ridx_nxt;
    rpar_r    <= rpar_nxt;
    rzero_r   <= rzero_nxt;
    out_re_r  <= out_re_nxt;
    out_im_r  <= out_im_nxt;
    out_idx_r <= out_idx_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_amp_real  = out_re_r;
  assign out_amp_imag  = out_im_r;
  assign out_amp_index = out_idx_r;

endmodule

FILE: hdl/qsvg_checker.sv
// qsvg_checker: port-level assertions for qubit_state_vector_gates, and its bind.
// Depends on qsvg_pkg.
module qsvg_checker #(
  parameter int AMP_WIDTH = 18
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [2:0]           in_action,
  input logic [5:0]           in_read_index,
  input logic                 cfg_wr_en,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [AMP_WIDTH-1:0] out_amp_real,
  input logic [5:0]           out_amp_index
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_amp_real) && $stable(out_amp_index))
    else $error("result changed while stalled");

  // init request starts a clearing pass
  a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == qsvg_pkg::ACT_INIT) |=> !in_ready)
    else $error("init request did not block requests");

  // a register write reinitializes the vector
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_ready)
    else $error("register write did not start clearing");

  // a read into a free result slot is answered through the S_READ state and the result register, with its index
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == qsvg_pkg::ACT_READ) && !out_valid |->
      ##2 (out_valid && (out_amp_index == $past(in_read_index, 2))))
    else $error("read result late or wrong index");

  // a new result appears only as the block returns to accepting requests
  a_rise_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while block busy");

endmodule

bind qubit_state_vector_gates qsvg_checker #(.AMP_WIDTH(AMP_WIDTH)) u_qsvg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_action     (in_action),
  .in_read_index (in_read_index),
  .cfg_wr_en     (cfg_wr_en),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_amp_real  (out_amp_real),
  .out_amp_index (out_amp_index)
);

FILE: verif/amp_vector_checker.sv
// amp_vector_checker: watches the request, result and num_qubits ports of the
// state-vector gate engine, keeps its own amplitude vector and checks every read.
// Depends on qsvg_pkg for the instruction codes.
module amp_vector_checker #(
  parameter int MAX_QUBITS = 6,
  parameter int AMP_WIDTH  = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [2:0]                  in_action,
  input  logic                        in_all_qubits,
  input  logic [2:0]                  in_target_qubit,
  input  logic [2:0]                  in_control_qubit,
  input  logic [5:0]                  in_read_index,
  input  logic                        cfg_wr_en,
  input  logic [2:0]                  cfg_wr_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [AMP_WIDTH-1:0] out_amp_real,
  input  logic signed [AMP_WIDTH-1:0] out_amp_imag,
  input  logic [5:0]                  out_amp_index,
  output int                          mismatches,
  output int                          amps_outstanding
);

  localparam int     VEC_LEN   = 1 << MAX_QUBITS;
  localparam int     FRAC      = 16;
  localparam longint AMP_HI    = (longint'(1) << (AMP_WIDTH - 1)) - 1;
  localparam longint AMP_LO    = -AMP_HI - 1;
  localparam longint ROOT_HALF = 46341;  // 1/sqrt(2) in Q16, rounded
  localparam longint ONE_Q16   = longint'(1) << FRAC;

  typedef struct {
    logic signed [AMP_WIDTH-1:0] re;
    logic signed [AMP_WIDTH-1:0] im;
    logic [5:0]                  idx;
  } amp_sample_t;

  int          vec_re [VEC_LEN];
  int          vec_im [VEC_LEN];
  int          live_qubits = 1;
  amp_sample_t amp_expected [$];
  int          err_total = 0;
  int          pend_total = 0;

  assign mismatches       = err_total;
  assign amps_outstanding = pend_total;

  function automatic int h_scale(longint x);
    longint p;
    p = (x * ROOT_HALF + (longint'(1) << (FRAC - 1))) >>> FRAC;
    if (p > AMP_HI) p = AMP_HI;
    else if (p < AMP_LO) p = AMP_LO;
    return int'(p);
  endfunction

  function automatic void clear_vector();
    int k;
    for (k = 0; k < VEC_LEN; k++) begin
      vec_re[k] = 0;
      vec_im[k] = 0;
    end
    vec_re[0] = int'((ONE_Q16 > AMP_HI) ? AMP_HI : ONE_Q16);
  endfunction

  function automatic void swap_pair(int i, int j);
    int t;
    t = vec_re[i]; vec_re[i] = vec_re[j]; vec_re[j] = t;
    t = vec_im[i]; vec_im[i] = vec_im[j]; vec_im[j] = t;
  endfunction

  function automatic void hadamard_pass(int q);
    int     i, j, bitv;
    longint ar, br, ai, bi;
    bitv = 1 << q;
    for (i = 0; i < (1 << live_qubits); i++) begin
      if ((i & bitv) == 0) begin
        j  = i | bitv;
        ar = vec_re[i]; br = vec_re[j];
        ai = vec_im[i]; bi = vec_im[j];
        vec_re[i] = h_scale(ar + br);
        vec_re[j] = h_scale(ar - br);
        vec_im[i] = h_scale(ai + bi);
        vec_im[j] = h_scale(ai - bi);
      end
    end
  endfunction

  function automatic void not_pass(int q);
    int i, bitv;
    bitv = 1 << q;
    for (i = 0; i < (1 << live_qubits); i++)
      if ((i & bitv) == 0) swap_pair(i, i | bitv);
  endfunction

  function automatic void cnot_pass(int tq, int cq);
    int i, tb, cb;
    tb = 1 << tq;
    cb = 1 << cq;
    for (i = 0; i < (1 << live_qubits); i++)
      if ((i & tb) == 0 && (i & cb) != 0) swap_pair(i, i | tb);
  endfunction

  always @(posedge clk) begin
    amp_sample_t got, want;
    int          bad, q, v, tq, cq;
    bad = 0;
    tq  = int'(in_target_qubit);
    cq  = int'(in_control_qubit);
    if (!rst_n) begin
      live_qubits = 1;
      clear_vector();
      amp_expected.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.re  = out_amp_real;
        got.im  = out_amp_imag;
        got.idx = out_amp_index;
        if (amp_expected.size() == 0) begin
          $display("%0t: amplitude with no read pending: index %0d real %0d imag %0d",
                   $time, got.idx, got.re, got.im);
          bad++;
        end else begin
          want = amp_expected.pop_front();
          if (got.idx !== want.idx) begin
            $display("%0t: amp_index expected %0d, got %0d", $time, want.idx, got.idx);
            bad++;
          end
          if (got.re !== want.re) begin
            $display("%0t: amp_real [%0d] expected %0d, got %0d",
                     $time, want.idx, want.re, got.re);
            bad++;
          end
          if (got.im !== want.im) begin
            $display("%0t: amp_imag [%0d] expected %0d, got %0d",
                     $time, want.idx, want.im, got.im);
            bad++;
          end
        end
      end

      // a qubit-count write clamps to 1..MAX_QUBITS and resets to |0..0>
      if (cfg_wr_en) begin
        v = int'(cfg_wr_data);
        if (v < 1) v = 1;
        if (v > MAX_QUBITS) v = MAX_QUBITS;
        live_qubits = v;
        clear_vector();
      end

      if (in_valid && in_ready) begin
        case (in_action)
          qsvg_pkg::ACT_INIT: clear_vector();
          qsvg_pkg::ACT_HAD: begin
            if (in_all_qubits) begin
              for (q = 0; q < live_qubits; q++) hadamard_pass(q);
            end else if (tq < live_qubits) begin
              hadamard_pass(tq);
            end
          end
          qsvg_pkg::ACT_NOT: begin
            if (in_all_qubits) begin
              for (q = 0; q < live_qubits; q++) not_pass(q);
            end else if (tq < live_qubits) begin
              not_pass(tq);
            end
          end
          qsvg_pkg::ACT_CNOT: begin
            if (tq < live_qubits && cq < live_qubits && tq != cq)
              cnot_pass(tq, cq);
          end
          qsvg_pkg::ACT_READ: begin
            // entries past the live vector stay zero, so no range check needed
            want.re  = AMP_WIDTH'(vec_re[in_read_index]);
            want.im  = AMP_WIDTH'(vec_im[in_read_index]);
            want.idx = in_read_index;
            amp_expected.push_back(want);
          end
          default: ;  // spare codes are dropped
        endcase
      end
    end
    err_total  <= err_total + bad;
    pend_total <= amp_expected.size();
  end

endmodule

FILE: verif/tb_qubit_state_vector_gates.sv
// tb_qubit_state_vector_gates: directed then random gate/read requests into the
// state-vector gate engine, with bursty sender and patterned receiver stalls.
// Depends on qsvg_pkg, qubit_state_vector_gates and amp_vector_checker.
module tb_qubit_state_vector_gates;

  localparam int MAX_Q = 6;
  localparam int AMP_W = 18;

  // Worst quiet time of a correct block: an all-qubit gate at six qubits is
  // six passes over the pairs; a qubit-count write adds a clearing pass.
  localparam int DRAIN_CYCLES    = 300;
  localparam int STALL_LIMIT     = 5000;
  localparam int RANDOM_REQUESTS = 1450;

  // action codes past ACT_READ: the block must drop these silently
  localparam logic [2:0] ACT_SPARE_LO = 3'(qsvg_pkg::ACT_READ) + 3'd1;
  localparam logic [2:0] ACT_SPARE_HI = 3'b111;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [2:0]              in_action;
  logic                    in_all_qubits;
  logic [2:0]              in_target_qubit;
  logic [2:0]              in_control_qubit;
  logic [5:0]              in_read_index;
  logic                    cfg_wr_en;
  logic [2:0]              cfg_wr_data;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [AMP_W-1:0] out_amp_real;
  logic signed [AMP_W-1:0] out_amp_imag;
  logic [5:0]              out_amp_index;
  int                      mismatches;
  int                      amps_outstanding;

  int                      live_qubits = 1;   // mirror of the register, for stimulus
  int                      burst_left = 1;    // requests left before the next sender gap

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  qubit_state_vector_gates #(
    .MAX_QUBITS (MAX_Q),
    .AMP_WIDTH  (AMP_W)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_all_qubits    (in_all_qubits),
    .in_target_qubit  (in_target_qubit),
    .in_control_qubit (in_control_qubit),
    .in_read_index    (in_read_index),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_amp_real     (out_amp_real),
    .out_amp_imag     (out_amp_imag),
    .out_amp_index    (out_amp_index)
  );

  amp_vector_checker #(
    .MAX_QUBITS (MAX_Q),
    .AMP_WIDTH  (AMP_W)
  ) u_amp_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_all_qubits    (in_all_qubits),
    .in_target_qubit  (in_target_qubit),
    .in_control_qubit (in_control_qubit),
    .in_read_index    (in_read_index),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_amp_real     (out_amp_real),
    .out_amp_imag     (out_amp_imag),
    .out_amp_index    (out_amp_index),
    .mismatches       (mismatches),
    .amps_outstanding (amps_outstanding)
  );

  // Receiver: a 16-bit ready pattern, replaced each time a random hold count runs out.
  // One flavor never stalls; the others always keep at least one ready slot.
  logic [15:0] ready_pat = 16'hFFFF;
  logic [3:0]  pat_pos = 4'd0;
  int          pat_left = 0;

  always @(posedge clk) begin
    if (pat_left == 0) begin
      pat_left <= $urandom_range(100, 600);
      case ($urandom_range(0, 3))
        0:       ready_pat <= 16'hFFFF;
        1:       ready_pat <= 16'($urandom) | 16'h0101;
        2:       ready_pat <= 16'h0001 << $urandom_range(0, 15);  // long stalls
        default: ready_pat <= 16'($urandom) | 16'h0001;
      endcase
    end else begin
      pat_left <= pat_left - 1;
    end
    pat_pos   <= pat_pos + 4'd1;
    out_ready <= ready_pat[pat_pos];
  end

  // Watchdog: too long without a request or a result taken means a hang.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one request and hold it until taken, then maybe open a gap.
  // The gap is never empty, so valid never drops and rises
  // in the same step.
  task automatic issue(input logic [2:0] act, input logic all_q, input logic [2:0] tgt,
                       input logic [2:0] ctl, input logic [5:0] idx);
    in_valid         <= 1'b1;
    in_action        <= act;
    in_all_qubits    <= all_q;
    in_target_qubit  <= tgt;
    in_control_qubit <= ctl;
    in_read_index    <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Sender holds off until every read request has been answered.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (amps_outstanding != 0) @(posedge clk);
  endtask

  // Qubit-count write: only once the block is idle. Gates give no result,
  // so after the last read comes back wait out the longest gate too.
  task automatic set_qubits(input logic [2:0] v);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    live_qubits = (v < 1) ? 1 : (v > MAX_Q) ? MAX_Q : int'(v);
  endtask

  initial begin
    logic [2:0] act, tgt, ctl;
    logic       all_q;
    logic [5:0] idx;
    int         sel, phase_len, sent;

    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_action        <= qsvg_pkg::ACT_INIT;
    in_all_qubits    <= 1'b0;
    in_target_qubit  <= 3'd0;
    in_control_qubit <= 3'd0;
    in_read_index    <= 6'd0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= 3'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed ----
    // reset state, one qubit: |0> and a read past the vector
    issue(qsvg_pkg::ACT_READ, 1'b0, 3'd0, 3'd0, 6'd0);
    issue(qsvg_pkg::ACT_READ, 1'b0, 3'd0, 3'd0, 6'd63);

    // write 7: clamps to six qubits
    set_qubits(3'd7);
    issue(qsvg_pkg::ACT_HAD,  1'b1, 3'd7, 3'd0, 6'd0);  // uniform superposition
    issue(qsvg_pkg::ACT_READ, 1'b0, 3'd0, 3'd0, 6'd0);
    issue(qsvg_pkg::ACT_READ, 1'b0, 3'd0, 3'd0, 6'd63);
    issue(qsvg_pkg::ACT_NOT,  1'b0, 3'd5, 3'd0, 6'd0);  // top qubit
    issue(qsvg_pkg::ACT_READ, 1'b0, 3'd0, 3'd0, 6'd32);
    issue(qsvg_pkg::ACT_CNOT, 1'b0, 3'd0, 3'd5, 6'd0);
    issue(qsvg_pkg::ACT_CNOT, 1'b0, 3'd3, 3'd3, 6'd0);  // control equals target: dropped
    issue(qsvg_pkg::ACT_CNOT, 1'b0, 3'd7, 3'd0, 6'd0);  // target out of range: dropped
    issue(qsvg_pkg::ACT_HAD,  1'b0, 3'd6, 3'd0, 6'd0);  // out of range: dropped
    issue(qsvg_pkg::ACT_NOT,  1'b0, 3'd7, 3'd7, 6'd63); // out of range: dropped
    issue(ACT_SPARE_LO, 1'b1, 3'd0, 3'd0, 6'd0);
    issue(ACT_SPARE_HI, 1'b0, 3'd0, 3'd0, 6'd0);
    drain_results();                                     // explicit hold-off mid-run
    issue(qsvg_pkg::ACT_INIT, 1'b0, 3'd0, 3'd0, 6'd0);
    issue(qsvg_pkg::ACT_HAD,  1'b0, 3'd0, 3'd0, 6'd0);
    issue(qsvg_pkg::ACT_CNOT, 1'b0, 3'd1, 3'd0, 6'd0);  // Bell pair on qubits 0 and 1
    issue(qsvg_pkg::ACT_READ, 1'b0, 3'd0, 3'd0, 6'd3);
    issue(qsvg_pkg::ACT_READ, 1'b0, 3'd0, 3'd0, 6'd0);
    issue(qsvg_pkg::ACT_NOT,  1'b1, 3'd0, 3'd0, 6'd0);
    issue(qsvg_pkg::ACT_READ, 1'b0, 3'd0, 3'd0, 6'd60);

    // write 0: clamps to one qubit
    set_qubits(3'd0);
    issue(qsvg_pkg::ACT_READ, 1'b0, 3'd0, 3'd0, 6'd1);
    issue(qsvg_pkg::ACT_READ, 1'b0, 3'd0, 3'd0, 6'd2);  // past the vector
    issue(qsvg_pkg::ACT_HAD,  1'b1, 3'd0, 3'd0, 6'd0);
    issue(qsvg_pkg::ACT_READ, 1'b0, 3'd0, 3'd0, 6'd1);

    // ---- random phases, each at a fresh qubit count ----
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      set_qubits(3'($urandom_range(0, 7)));
      phase_len = $urandom_range(60, 160);
      repeat (phase_len) begin
        if ($urandom_range(0, 149) == 0) drain_results();
        if ($urandom_range(0, 9) < 7) begin
          // well-formed: qubits in range, reads inside the live vector
          sel   = $urandom_range(0, 99);
          all_q = ($urandom_range(0, 3) == 0);
          tgt   = 3'($urandom_range(0, live_qubits - 1));
          ctl   = (live_qubits > 1)
                  ? 3'((tgt + $urandom_range(1, live_qubits - 1)) % live_qubits) : tgt;
          idx   = 6'($urandom_range(0, (1 << live_qubits) - 1));
          if (sel < 35)      act = qsvg_pkg::ACT_READ;
          else if (sel < 55) act = qsvg_pkg::ACT_HAD;
          else if (sel < 68) act = qsvg_pkg::ACT_NOT;
          else if (sel < 96) act = qsvg_pkg::ACT_CNOT;
          else               act = qsvg_pkg::ACT_INIT;
        end else begin
          // noise: any field value, spare codes and out-of-range qubits included
          act   = 3'($urandom_range(0, 7));
          all_q = 1'($urandom);
          tgt   = 3'($urandom_range(0, 7));
          ctl   = 3'($urandom_range(0, 7));
          idx   = 6'($urandom_range(0, 63));
        end
        issue(act, all_q, tgt, ctl, idx);
        sent++;
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && amps_outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/qsvg_pkg.sv
hdl/qsvg_ram.sv
hdl/qsvg_bfly.sv
hdl/qsvg_seq.sv
hdl/qubit_state_vector_gates.sv
hdl/qsvg_checker.sv
verif/amp_vector_checker.sv
verif/tb_qubit_state_vector_gates.sv
